// File: rtl/cmf_pkg.sv
// Shared types, constants and the five-value median function of the cross median filter.
// No dependencies; every other file in rtl/ imports this package.
package cmf_pkg;

  localparam int CHAN_W            = 8;
  localparam int PIX_W             = 4 * CHAN_W;
  localparam int CFG_WIDTH_W       = 12;
  localparam int CFG_HEIGHT_W      = 16;
  localparam int CFG_DATA_W        = 16;
  localparam int CFG_INDEX_W       = 1;
  localparam int MAX_WIDTH_DEFAULT = 2048;

  localparam logic [CFG_WIDTH_W-1:0]  DEFAULT_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_HEIGHT_W-1:0] DEFAULT_FRAME_HEIGHT = 16'd480;

  // Register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Item kinds on the pixel channel
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // How an optional neighborhood slot enters the median: its own value, or a
  // low or high pad that keeps the upper-middle element in the center
  localparam logic [1:0] SLOT_USE  = 2'd0;
  localparam logic [1:0] SLOT_LOW  = 2'd1;
  localparam logic [1:0] SLOT_HIGH = 2'd2;

  typedef logic [PIX_W-1:0] pixel_t;  // red in [7:0] up to alpha in [31:24]

  typedef struct packed {
    logic              kind;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;
    logic [CHAN_W-1:0] alpha_in;
  } pix_word_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [CHAN_W-1:0] alpha_out;
    logic              frame_end;
  } res_word_t;

  // One column of the two line stores
  typedef struct packed {
    pixel_t up;
    pixel_t mid;
  } line_entry_t;

  // Decision for one accepted word
  typedef struct packed {
    logic            flush;
    logic            write;
    logic            produce;
    logic            frame_end;
    logic [3:0][1:0] fill;
  } step_t;

  // Median of five bytes: drop the smallest of the first four, then take the
  // second smallest of the remaining four
  function automatic logic [CHAN_W-1:0] median5(input logic [CHAN_W-1:0] a,
                                                input logic [CHAN_W-1:0] b,
                                                input logic [CHAN_W-1:0] c,
                                                input logic [CHAN_W-1:0] d,
                                                input logic [CHAN_W-1:0] e);
    logic [CHAN_W-1:0] p0, p1, q0, q1, x0, x1, y, r0, r1;
    p0 = (a < b) ? a : b;
    p1 = (a < b) ? b : a;
    q0 = (c < d) ? c : d;
    q1 = (c < d) ? d : c;
    if (p0 <= q0) begin
      x0 = q0;
      x1 = q1;
      y  = p1;
    end else begin
      x0 = p0;
      x1 = p1;
      y  = q1;
    end
    r0 = (e < y) ? e : y;
    r1 = (e < y) ? y : e;
    if (r0 <= x0) begin
      return (r1 < x0) ? r1 : x0;
    end
    return (r0 < x1) ? r0 : x1;
  endfunction

endpackage

// File: rtl/cmf_ctrl.sv
// Configuration registers, position counters and per-word step decision.
// Depends on cmf_pkg.
module cmf_ctrl
  import cmf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   accept,
  input  logic                   kind,
  output step_t                  step,
  output logic [AW-1:0]          col,
  output logic [AW-1:0]          col_right
);

  localparam int WC = (AW + 1 > CFG_WIDTH_W) ? AW + 1 : CFG_WIDTH_W;

  logic [CFG_WIDTH_W-1:0]  frame_width;
  logic [CFG_HEIGHT_W-1:0] frame_height;
  logic [AW-1:0]           in_column, in_column_next;
  logic [CFG_HEIGHT_W-1:0] in_row, in_row_next;
  logic [AW-1:0]           out_column, out_column_next;

  logic [WC-1:0]           w;
  logic [CFG_HEIGHT_W-1:0] h;
  logic                    pix_wrap;
  logic [AW-1:0]           c_pix;
  logic [CFG_HEIGHT_W-1:0] r_pix;
  logic [CFG_HEIGHT_W:0]   r_pix_inc;
  logic                    live;
  logic                    drain;
  logic                    over;
  logic [AW-1:0]           c;
  logic [AW:0]             c_inc;
  logic                    eol;
  logic [3:0]              present;
  logic [1:0]              miss;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= DEFAULT_FRAME_WIDTH;
      frame_height <= DEFAULT_FRAME_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[CFG_WIDTH_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[CFG_HEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp frame size to the range in use
  always_comb begin
    if (frame_width == '0) begin
      w = WC'(1);
    end else if (WC'(frame_width) > WC'(MAX_WIDTH)) begin
      w = WC'(MAX_WIDTH);
    end else begin
      w = WC'(frame_width);
    end
    h = (frame_height == '0) ? CFG_HEIGHT_W'(1) : frame_height;
  end

  // Position of a pixel word, after an early row end
  assign pix_wrap  = WC'(in_column) >= w;
  assign c_pix     = pix_wrap ? '0 : in_column;
  assign r_pix     = pix_wrap ? CFG_HEIGHT_W'(in_row + 1'b1) : in_row;
  assign r_pix_inc = {1'b0, r_pix} + 1'b1;
  assign live      = r_pix < h;

  // Drain state for flush ticks
  assign drain = in_row >= h;
  assign over  = WC'(out_column) >= w;

  // Column shared by both kinds
  assign c         = (kind == KIND_FLUSH) ? out_column : c_pix;
  assign c_inc     = {1'b0, c} + 1'b1;
  assign eol       = WC'(c_inc) >= w;
  assign col       = c;
  assign col_right = c_inc[AW-1:0];

  // Decide what this word does and which neighbors exist
  always_comb begin
    step.flush     = (kind == KIND_FLUSH);
    step.write     = 1'b0;
    step.produce   = 1'b0;
    step.frame_end = 1'b0;
    if (kind == KIND_FLUSH) begin
      step.produce   = drain && !over;
      step.frame_end = drain && !over && eol;
      present        = {!eol, (c != '0), 1'b0, (h > CFG_HEIGHT_W'(1))};
    end else begin
      step.write   = live;
      step.produce = live && (r_pix != '0);
      present      = {!eol, (c != '0), (r_pix > CFG_HEIGHT_W'(1)), 1'b1};
    end
    // Pad missing slots high, low, high, low so the upper middle stays central
    miss = '0;
    for (int i = 0; i < 4; i++) begin
      if (present[i]) begin
        step.fill[i] = SLOT_USE;
      end else begin
        step.fill[i] = miss[0] ? SLOT_LOW : SLOT_HIGH;
        miss         = miss + 1'b1;
      end
    end
  end

  // Advance position counters
  always_comb begin
    in_column_next  = in_column;
    in_row_next     = in_row;
    out_column_next = out_column;
    if (kind == KIND_FLUSH) begin
      if (drain) begin
        if (over || eol) begin
          in_column_next  = '0;
          in_row_next     = '0;
          out_column_next = '0;
        end else begin
          out_column_next = c_inc[AW-1:0];
        end
      end
    end else begin
      in_column_next = c_pix;
      in_row_next    = r_pix;
      if (live) begin
        if (r_pix != '0) begin
          out_column_next = eol ? '0 : c_inc[AW-1:0];
        end
        if (eol) begin
          in_column_next = '0;
          in_row_next    = r_pix_inc[CFG_HEIGHT_W-1:0];
          if (r_pix_inc >= {1'b0, h}) begin
            out_column_next = '0;
          end
        end else begin
          in_column_next = c_inc[AW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_column  <= '0;
      in_row     <= '0;
      out_column <= '0;
    end else if (accept) begin
      in_column  <= in_column_next;
      in_row     <= in_row_next;
      out_column <= out_column_next;
    end
  end

  // The last result of a frame returns every counter to the origin
  a_frame_end_clears : assert property (@(posedge clk) disable iff (rst)
    (accept && kind == KIND_FLUSH && step.produce && step.frame_end) |=>
    (in_column == '0 && in_row == '0 && out_column == '0))
    else $error("counters not cleared after frame end");

endmodule

// File: rtl/cmf_line_mem.sv
// Line store memory: one entry per column holding the upper and middle rows,
// one write port and two registered read ports with same-edge write forwarding.
// Depends on cmf_pkg.
module cmf_line_mem
  import cmf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr_a,
  input  logic [AW-1:0] rd_addr_b,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  line_entry_t   wr_data,
  output line_entry_t   rd_data_a,
  output line_entry_t   rd_data_b
);

  line_entry_t mem [0:MAX_WIDTH-1];
  line_entry_t q_a, q_b, fwd;
  logic        hit_a, hit_b;

  // Read old contents; catch a write that lands on a read address this edge
  always_ff @(posedge clk) begin
    if (rd_en) begin
      q_a   <= mem[rd_addr_a];
      q_b   <= mem[rd_addr_b];
      hit_a <= wr_en && (wr_addr == rd_addr_a);
      hit_b <= wr_en && (wr_addr == rd_addr_b);
      fwd   <= wr_data;
    end
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  assign rd_data_a = hit_a ? fwd : q_a;
  assign rd_data_b = hit_b ? fwd : q_b;

endmodule

// File: rtl/cmf_median.sv
// Per-channel five-point median with padding of missing neighbors.
// Depends on cmf_pkg (median5, slot codes).
module cmf_median
  import cmf_pkg::*;
(
  input  pixel_t          center,
  input  pixel_t          nbr [4],
  input  logic [3:0][1:0] fill,
  output pixel_t          med
);

  logic [CHAN_W-1:0] v [4][4];

  // Substitute pads for missing neighbors
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      for (int i = 0; i < 4; i++) begin
        case (fill[i])
          SLOT_USE:  v[ch][i] = nbr[i][CHAN_W*ch +: CHAN_W];
          SLOT_LOW:  v[ch][i] = '0;
          SLOT_HIGH: v[ch][i] = '1;
          default:   v[ch][i] = nbr[i][CHAN_W*ch +: CHAN_W];
        endcase
      end
    end
  end

  // Select the median of each channel
  always_comb begin
    for (int ch = 0; ch < 4; ch++) begin
      med[CHAN_W*ch +: CHAN_W] = median5(center[CHAN_W*ch +: CHAN_W],
                                         v[ch][0], v[ch][1], v[ch][2], v[ch][3]);
    end
  end

endmodule

// File: rtl/cross_median_filter_rgba.sv
// Top level of the RGBA five-point cross median filter.
// Depends on cmf_pkg, cmf_ctrl, cmf_line_mem and cmf_median.
//   Pixel channel (pix_valid/pix_ready/pix_word) carries one word per pixel
//   in raster order, kind = pixel, or a flush tick, kind = flush. Result
//   channel (res_valid/res_ready/res_word) gives the per-channel median of
//   each pixel over itself and its in-frame up, down, left and right
//   neighbors, with frame_end set on the last pixel of the frame.
//   Results lag one row: row 0 gives nothing, each later pixel gives the
//   result for the pixel above it, and after the last pixel one flush tick
//   per column drains the last row. Flush ticks with nothing pending and
//   pixels sent while the last row drains give no result.
//   A result passes through the input/line-read register, then the result
//   register. Throughput: one word per cycle unless the receiver stalls; the
//   line store has one write and two read ports, and the median is
//   combinational between the registers.
//   Reset clears the position counters and sets the frame to 640 x 480; the
//   line store is not cleared and needs no clearing pass.
//   Configuration writes (cfg_write, cfg_index, cfg_data) act at once, idle only.
//   On a receiver stall the result word holds, words with no result pass, one
//   producing word waits in the input stage, and then pix_ready drops.
module cross_median_filter_rgba
  import cmf_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   pix_valid,
  output logic                   pix_ready,
  input  pix_word_t              pix_word,
  output logic                   res_valid,
  input  logic                   res_ready,
  output res_word_t              res_word
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic          accept;
  step_t         step;
  logic [AW-1:0] col, col_right;

  logic          s1_valid;
  step_t         s1_step;
  logic [AW-1:0] s1_col;
  pixel_t        s1_pix;
  logic          s1_adv;

  line_entry_t   rd_a, rd_b, wr_data;
  logic          wr_en;
  pixel_t        cache_up, cache_mid;
  pixel_t        nbr [4];
  pixel_t        med;

  assign accept    = pix_valid && pix_ready;
  assign s1_adv    = s1_valid && (!s1_step.produce || !res_valid || res_ready);
  assign pix_ready = !s1_valid || s1_adv;

  cmf_ctrl #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .kind      (pix_word.kind),
    .step      (step),
    .col       (col),
    .col_right (col_right)
  );

  // Store the row above as the new upper row and the pixel as the middle row
  assign wr_en   = s1_adv && s1_step.write;
  assign wr_data = '{up: rd_a.mid, mid: s1_pix};

  cmf_line_mem #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_line_mem (
    .clk       (clk),
    .rd_en     (accept),
    .rd_addr_a (col),
    .rd_addr_b (col_right),
    .wr_en     (wr_en),
    .wr_addr   (s1_col),
    .wr_data   (wr_data),
    .rd_data_a (rd_a),
    .rd_data_b (rd_b)
  );

  // Input stage: hold the word while its line entries are read
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pix_ready) begin
      s1_valid <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_step <= step;
      s1_col  <= col;
      s1_pix  <= {pix_word.alpha_in, pix_word.blue_in, pix_word.green_in, pix_word.red_in};
    end
  end

  // Keep the column just left of the next one as it now stands in the store
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_step.write) begin
        cache_up  <= rd_a.mid;
        cache_mid <= s1_pix;
      end else if (s1_step.produce) begin
        cache_up  <= rd_a.up;
        cache_mid <= rd_a.mid;
      end
    end
  end

  // Gather the neighborhood; unused slots are padded by the fill codes
  assign nbr[0] = s1_step.flush ? rd_a.up : s1_pix;
  assign nbr[1] = rd_a.up;
  assign nbr[2] = s1_step.flush ? cache_mid : cache_up;
  assign nbr[3] = rd_b.mid;

  cmf_median u_median (
    .center (rd_a.mid),
    .nbr    (nbr),
    .fill   (s1_step.fill),
    .med    (med)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_step.produce) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_step.produce) begin
      res_word <= '{red_out:   med[CHAN_W-1:0],
                    green_out: med[2*CHAN_W-1:CHAN_W],
                    blue_out:  med[3*CHAN_W-1:2*CHAN_W],
                    alpha_out: med[4*CHAN_W-1:3*CHAN_W],
                    frame_end: s1_step.frame_end};
    end
  end

  // A new result only ever comes from a producing word leaving the input stage
  a_result_source : assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(s1_valid && s1_step.produce))
    else $error("result appeared without a producing word");

  // Input stalls only behind a held result and a waiting producing word
  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    !pix_ready |-> (s1_valid && s1_step.produce && res_valid && !res_ready))
    else $error("pixel channel stalled without cause");

endmodule

// File: sim/testbench.sv
// Self-checking testbench for cross_median_filter_rgba: drives frames of RGBA pixel words and
// flush ticks, predicts every median result word and checks each one as it leaves the block.
// Depends on cmf_pkg and the RTL top level only.
module testbench;
  import cmf_pkg::*;

  localparam int LINE_DEPTH     = MAX_WIDTH_DEFAULT;
  localparam int DRAIN_PAD      = 4;     // margin after the last expected result leaves
  localparam int RX_HOLD_CYCLES = 200;
  localparam int QUIET_LIMIT    = 2000;
  localparam int RANDOM_ITEMS   = 1200;
  localparam int MAX_REPORTS    = 100;

  // 3 x 3 frame with channel extremes and uneven mixes
  localparam pixel_t BORDER_PIX [9] = '{
    32'h00000000, 32'hFFFFFFFF, 32'h00FF00FF,
    32'hFF00FF00, 32'h01FE7F80, 32'hFFFFFFFF,
    32'h00000000, 32'h80808080, 32'hFE01807F
  };

  // Predictor of the filter: line stores, position counters, registers, queued results
  class median_scoreboard;
    pixel_t      up_line  [LINE_DEPTH];
    pixel_t      mid_line [LINE_DEPTH];
    pixel_t      hood [$];
    res_word_t   expected_q [$];
    int unsigned in_col, in_row, out_col;
    int unsigned width_reg, height_reg;
    int unsigned errors, results_seen;

    function new();
      foreach (up_line[i]) begin
        up_line[i]  = '0;
        mid_line[i] = '0;
      end
      width_reg    = 32'(DEFAULT_FRAME_WIDTH);
      height_reg   = 32'(DEFAULT_FRAME_HEIGHT);
      errors       = 0;
      results_seen = 0;
      clear_position();
    endfunction

    function void clear_position();
      in_col  = 0;
      in_row  = 0;
      out_col = 0;
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) begin
        width_reg = 32'(val[CFG_WIDTH_W-1:0]);
      end else begin
        height_reg = 32'(val);
      end
    endfunction

    function int unsigned active_width();
      if (width_reg == 0) return 1;
      if (width_reg > LINE_DEPTH) return LINE_DEPTH;
      return width_reg;
    endfunction

    // Append one pixel to the neighborhood
    function void hood_add(pixel_t p);
      hood.insert(hood.size(), p);
    endfunction

    // Queue one expected result word
    function void expect_word(res_word_t r);
      expected_q.insert(expected_q.size(), r);
    endfunction

    // Upper-middle element of one channel over the gathered neighborhood
    function logic [CHAN_W-1:0] hood_median(int ch);
      logic [CHAN_W-1:0] v [5];
      logic [CHAN_W-1:0] x;
      int n, j;
      n = hood.size();
      for (int i = 0; i < n; i++) begin
        x = hood[i][CHAN_W*ch +: CHAN_W];
        j = i;
        while (j > 0 && v[j-1] > x) begin
          v[j] = v[j-1];
          j--;
        end
        v[j] = x;
      end
      return v[n/2];
    endfunction

    function res_word_t hood_result(logic last);
      res_word_t r;
      r.red_out   = hood_median(0);
      r.green_out = hood_median(1);
      r.blue_out  = hood_median(2);
      r.alpha_out = hood_median(3);
      r.frame_end = last;
      return r;
    endfunction

    // Advance the model by one accepted word and queue the result it causes
    function void note_word(pix_word_t w);
      int unsigned wd, ht, c;
      pixel_t pix;
      wd = active_width();
      ht = (height_reg == 0) ? 1 : height_reg;
      hood.delete();
      if (w.kind == KIND_PIXEL) begin
        // a column past a shrunken width ends the row early
        if (in_col >= wd) begin
          in_col = 0;
          in_row++;
        end
        // drop pixels while the last row drains
        if (in_row >= ht) return;
        c   = in_col;
        pix = {w.alpha_in, w.blue_in, w.green_in, w.red_in};
        // from row 1 on, each pixel completes the one above it
        if (in_row >= 1) begin
          hood_add(mid_line[c]);
          hood_add(pix);
          if (in_row >= 2) hood_add(up_line[c]);
          if (c >= 1) hood_add(up_line[c-1]);
          if (c + 1 < wd) hood_add(mid_line[c+1]);
          expect_word(hood_result(1'b0));
          out_col = (c + 1 >= wd) ? 0 : c + 1;
        end
        up_line[c]  = mid_line[c];
        mid_line[c] = pix;
        in_col = c + 1;
        if (in_col >= wd) begin
          in_col = 0;
          in_row++;
          if (in_row >= ht) out_col = 0;
        end
      end else begin
        c = out_col;
        // nothing pending before the whole frame is in
        if (in_row < ht) return;
        // a drain position past a shrunken width ends the frame silently
        if (c >= wd) begin
          clear_position();
          return;
        end
        hood_add(mid_line[c]);
        if (ht >= 2) hood_add(up_line[c]);
        if (c >= 1) hood_add(mid_line[c-1]);
        if (c + 1 < wd) hood_add(mid_line[c+1]);
        expect_word(hood_result(c + 1 == wd));
        out_col = c + 1;
        if (out_col >= wd) clear_position();
      end
    endfunction

    function void report(string field, logic [CHAN_W-1:0] exp_v, logic [CHAN_W-1:0] got_v);
      errors++;
      if (errors <= MAX_REPORTS) begin
        $display("%0t: result %0d %s expected %0d, got %0d",
                 $time, results_seen, field, exp_v, got_v);
      end
    endfunction

    function void check_result(res_word_t got);
      res_word_t exp_w;
      results_seen++;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, got %h", $time, got);
        return;
      end
      exp_w = expected_q.pop_front();
      if (got.red_out !== exp_w.red_out) report("red_out", exp_w.red_out, got.red_out);
      if (got.green_out !== exp_w.green_out) report("green_out", exp_w.green_out, got.green_out);
      if (got.blue_out !== exp_w.blue_out) report("blue_out", exp_w.blue_out, got.blue_out);
      if (got.alpha_out !== exp_w.alpha_out) report("alpha_out", exp_w.alpha_out, got.alpha_out);
      if (got.frame_end !== exp_w.frame_end) begin
        report("frame_end", CHAN_W'(exp_w.frame_end), CHAN_W'(got.frame_end));
      end
    endfunction

    function void flag_leftovers();
      if (expected_q.size() != 0) begin
        errors += expected_q.size();
        $display("%0t: %0d result words never arrived", $time, expected_q.size());
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_write = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                   pix_valid = 1'b0;
  logic                   pix_ready;
  pix_word_t              pix_word  = '0;
  logic                   res_valid;
  logic                   res_ready = 1'b0;
  res_word_t              res_word;

  median_scoreboard sb;
  int unsigned tx_idle_pct  = 0;
  int unsigned rx_idle_pct  = 0;
  logic        rx_hold      = 1'b0;
  int unsigned quiet_cycles = 0;
  int unsigned pixels_sent  = 0;
  int unsigned flushes_sent = 0;
  int unsigned frames_done  = 0;
  int unsigned stream_items = 0;
  event        stall_rx;

  cross_median_filter_rgba i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_ready (pix_ready),
    .pix_word  (pix_word),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_word  (res_word)
  );

  always #2 clk = ~clk;

  // Hold off the receiver for a long stretch on request
  always begin
    @(stall_rx);
    rx_hold <= 1'b1;
    repeat (RX_HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Receiver: stall at random, or not at all when the rate is zero
  always @(posedge clk) begin
    if (rst || rx_hold) begin
      res_ready <= 1'b0;
    end else begin
      res_ready <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  // Check every result word taken
  always @(posedge clk) begin
    if (!rst && res_valid && res_ready) sb.check_result(res_word);
  end

  // Watchdog: end the run when no word moves for too long
  always @(posedge clk) begin
    if ((pix_valid && pix_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic pixel_t random_pixel();
    pixel_t px;
    for (int ch = 0; ch < 4; ch++) begin
      if ($urandom_range(9, 0) == 0) begin
        px[CHAN_W*ch +: CHAN_W] = $urandom_range(1, 0) ? 8'hFF : 8'h00;
      end else begin
        px[CHAN_W*ch +: CHAN_W] = CHAN_W'($urandom_range(255, 0));
      end
    end
    return px;
  endfunction

  // Offer one word, idling first at the sender's rate, and note it once taken
  task automatic send_word(input logic kind, input pixel_t px);
    pix_word_t w;
    w.kind     = kind;
    w.red_in   = px[7:0];
    w.green_in = px[15:8];
    w.blue_in  = px[23:16];
    w.alpha_in = px[31:24];
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      pix_valid <= 1'b0;
      @(posedge clk);
    end
    pix_valid <= 1'b1;
    pix_word  <= w;
    do @(posedge clk); while (!pix_ready);
    sb.note_word(w);
    if (kind == KIND_PIXEL) begin
      pixels_sent++;
    end else begin
      flushes_sent++;
    end
  endtask

  // Stop sending and let every expected result come out
  task automatic settle();
    pix_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_PAD) @(posedge clk);
  endtask

  // Write both size registers while the block is idle
  task automatic set_frame(input int unsigned wd, input int unsigned ht);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_data  <= CFG_DATA_W'(wd);
    @(posedge clk);
    sb.write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(wd));
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_data  <= CFG_DATA_W'(ht);
    @(posedge clk);
    sb.write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(ht));
    cfg_write <= 1'b0;
  endtask

  // One whole frame and its drain; noisy frames mix in words the block must ignore
  task automatic send_frame(input int unsigned wd, input int unsigned ht, input bit noisy);
    int unsigned ew, eh;
    set_frame(wd, ht);
    ew = (wd == 0) ? 1 : ((wd > LINE_DEPTH) ? LINE_DEPTH : wd);
    eh = (ht == 0) ? 1 : ht;
    for (int unsigned i = 0; i < ew * eh; i++) begin
      if (noisy && $urandom_range(99, 0) < 4) send_word(KIND_FLUSH, random_pixel());
      send_word(KIND_PIXEL, random_pixel());
    end
    for (int unsigned i = 0; i < ew; i++) begin
      if (noisy && $urandom_range(99, 0) < 4) send_word(KIND_PIXEL, random_pixel());
      send_word(KIND_FLUSH, random_pixel());
    end
    stream_items += ew * eh + ew;
    frames_done++;
  endtask

  // Mostly small frames, now and then wider or taller ones and zero-valued registers
  task automatic random_frames(input int unsigned quota);
    int unsigned base, wd, ht;
    base = stream_items;
    while (stream_items - base < quota) begin
      wd = ($urandom_range(9, 0) < 8) ? $urandom_range(8, 1) : $urandom_range(40, 9);
      ht = ($urandom_range(9, 0) < 9) ? $urandom_range(6, 1) : $urandom_range(12, 7);
      if ($urandom_range(19, 0) == 0) wd = 0;
      if ($urandom_range(19, 0) == 0) ht = 0;
      send_frame(wd, ht, $urandom_range(3, 0) != 0);
    end
  endtask

  initial begin
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Sender idles lightly, receiver heavily
    tx_idle_pct = 19;
    rx_idle_pct <= 53;

    // Full 3 x 3 frame: early flush, border and center pixels, pixel during drain
    set_frame(3, 3);
    send_word(KIND_FLUSH, random_pixel());
    for (int i = 0; i < 9; i++) send_word(KIND_PIXEL, BORDER_PIX[i]);
    send_word(KIND_PIXEL, 32'hFFFFFFFF);
    for (int i = 0; i < 3; i++) send_word(KIND_FLUSH, 32'h00000000);

    // Shrink the width inside row 0: the next pixel starts row 1
    set_frame(4, 2);
    send_word(KIND_PIXEL, 32'h10203040);
    send_word(KIND_PIXEL, 32'hF0E0D0C0);
    set_frame(2, 2);
    send_word(KIND_PIXEL, 32'h00FF00FF);
    send_word(KIND_PIXEL, 32'hFF00FF00);
    send_word(KIND_FLUSH, 32'hFFFFFFFF);
    send_word(KIND_FLUSH, 32'hFFFFFFFF);

    // Shrink the width inside the drain, then run a zero-by-zero frame
    set_frame(2, 1);
    send_word(KIND_PIXEL, 32'h7F7F7F7F);
    send_word(KIND_PIXEL, 32'h80808080);
    send_word(KIND_FLUSH, 32'h00000000);
    set_frame(0, 0);
    send_word(KIND_FLUSH, 32'h00000000);
    send_word(KIND_PIXEL, 32'hA5A5A5A5);
    send_word(KIND_FLUSH, 32'h5A5A5A5A);

    // Hold the receiver while the sender keeps offering words
    set_frame(6, 5);
    ->stall_rx;
    send_frame(6, 5, 1'b0);
    random_frames(RANDOM_ITEMS / 3);

    // Swap the idle rates
    tx_idle_pct = 53;
    rx_idle_pct <= 19;
    random_frames(RANDOM_ITEMS / 3);

    // Full rate
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    random_frames(RANDOM_ITEMS / 3);

    settle();
    sb.flag_leftovers();
    $display("testbench: %0d frames, %0d pixel words, %0d flush ticks, %0d result words checked",
             frames_done, pixels_sent, flushes_sent, sb.results_seen);
    $display("testbench: border, shrink and drain cases, long stall, sizes 1x1 up to 40x12");
    if (sb.errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

// File: cross_median_filter_rgba.f
rtl/cmf_pkg.sv
rtl/cmf_ctrl.sv
rtl/cmf_line_mem.sv
rtl/cmf_median.sv
rtl/cross_median_filter_rgba.sv
sim/testbench.sv
